### sv/stepper_speed_ramp_generator_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef STEPPER_SPEED_RAMP_GENERATOR_MACROS_SVH
`define STEPPER_SPEED_RAMP_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define SSRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssrg assertion failed");

// Next-cycle implication.
`define SSRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssrg assertion failed");

`endif

### sv/ssrg_pkg.sv
`timescale 1ns / 1ps
package ssrg_pkg;

    // request commands
    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_PULSE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // ramp phases
    localparam logic [1:0] PH_STOP  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_DECEL = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_ACCEL = 2'd0;
    localparam logic [1:0] CFG_DECEL = 2'd1;
    localparam logic [1:0] CFG_SPEED = 2'd2;

    localparam logic [15:0] ACCEL_RST = 16'd100;
    localparam logic [15:0] DECEL_RST = 16'd100;
    localparam logic [15:0] SPEED_RST = 16'd1000;

    localparam logic [15:0] PULSE_WIDTH       = 16'd40;
    localparam logic [15:0] SINGLE_STEP_DELAY = 16'd1000;
    localparam logic [22:0] MIN_DELAY_NUM     = 23'd6000000;
    localparam logic [18:0] ALPHA_SQ_X        = 19'd394384;
    localparam logic [13:0] FIRST_SCALE       = 14'd10000;

    // a*628/100 == (a * M_RECIP) >> M_SHIFT, exact for any 16-bit a
    localparam logic [31:0] M_RECIP = 32'd3371549409;
    localparam int          M_SHIFT = 29;

    // divider geometry
    localparam int NUM_W = 48;
    localparam int DEN_W = 34;
    localparam int CNT_W = 6;

    // isqrt: operand below 2^20, so 10 digit steps
    localparam int          SQ_W     = 20;
    localparam logic [3:0]  SQ_FIRST = 4'd9;

    // datapath operations
    localparam int OP_W = 5;
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_NONE        = 5'd0;
    localparam t_op OP_ACCEPT      = 5'd1;
    localparam t_op OP_MOVE_SHORT  = 5'd2;
    localparam t_op OP_DIV_FLOOR   = 5'd3;
    localparam t_op OP_DIV_X       = 5'd4;
    localparam t_op OP_SQRT        = 5'd5;
    localparam t_op OP_SCALE_M     = 5'd6;
    localparam t_op OP_DIV_MAXS    = 5'd7;
    localparam t_op OP_DIV_LIM     = 5'd8;
    localparam t_op OP_DIV_K       = 5'd9;
    localparam t_op OP_PLAN_END    = 5'd10;
    localparam t_op OP_PULSE       = 5'd11;
    localparam t_op OP_HALT        = 5'd12;
    localparam t_op OP_TICK_SIMPLE = 5'd13;
    localparam t_op OP_DIV_DELAY   = 5'd14;
    localparam t_op OP_TICK_END    = 5'd15;
    localparam t_op OP_EMIT        = 5'd16;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic       unit_done;
        logic       moving;
        logic       steps_lt2;
        logic [1:0] cmd;
        logic [1:0] phase;
        logic       lim_le_max;
        logic       out_free;
    } t_dp_stat;

endpackage

### sv/stepper_speed_ramp_generator.sv
`timescale 1ns / 1ps
// Trapezoidal step-rate generator for a stepper motor.
// Request channel (i_in_valid / o_in_stall): i_cmd = move (step count,
// direction), step pulse done, control tick or stop. Result channel
// (o_out_valid / i_out_stall): one result per request, showing the ramp
// state after it: period, compare value, pulse enable, direction, busy,
// pulse count and phase. Config port: i_cfg_we writes accel, decel or
// top speed at index i_cfg_addr; write only while idle.
// Timing: one request at a time, stall held from acceptance until the result
// is loaded. Pulse, stop, plain ticks and moves under two steps use no divider.
// Accel/decel ticks run one pass of the shared restoring divider. A planned
// move runs four or five divider passes plus a 10-step isqrt; the fifth pass
// is skipped when the decel index needs no divide. The divider produces one
// quotient bit per cycle.
// A finished result sits in the output register; a stalled receiver holds
// it and the next request is taken but its result waits for the slot.
// Synchronous reset restores default config, phase STOP, all counts zero.
module stepper_speed_ramp_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [23:0] i_step_total,
    input  logic        i_forward,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_period,
    output logic [15:0] o_compare_value,
    output logic        o_pulse_enable,
    output logic        o_clockwise,
    output logic        o_busy_res,
    output logic [31:0] o_steps_done,
    output logic [1:0]  o_phase
);
    import ssrg_pkg::*;

    `include "stepper_speed_ramp_generator_macros.svh"

    t_dp_cmd  ctl;
    t_dp_stat stat;

    // sequencer: walks the plan / tick steps
    ssrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    // ramp state, divider, isqrt, output register
    ssrg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (i_cmd),
        .i_step_total    (i_step_total),
        .i_forward       (i_forward),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_period        (o_period),
        .o_compare_value (o_compare_value),
        .o_pulse_enable  (o_pulse_enable),
        .o_clockwise     (o_clockwise),
        .o_busy_res      (o_busy_res),
        .o_steps_done    (o_steps_done),
        .o_phase         (o_phase)
    );

    // enable and busy are set and cleared together
    `SSRG_ASSERT_IMP(a_en_busy, i_clk, i_rst_n, o_out_valid, o_pulse_enable == o_busy_res)
    // any phase but STOP implies a move in progress
    `SSRG_ASSERT_IMP(a_phase_busy, i_clk, i_rst_n, o_out_valid && (o_phase != PH_STOP), o_busy_res)
    // one request at a time
    `SSRG_ASSERT_NEXT(a_acc_stall, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
endmodule

### sv/ssrg_div.sv
`timescale 1ns / 1ps
module ssrg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ssrg_pkg::NUM_W-1:0]  i_num,
    input  logic [ssrg_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [ssrg_pkg::NUM_W-1:0]  o_quo,
    output logic [ssrg_pkg::DEN_W-1:0]  o_rem
);
    import ssrg_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [DEN_W:0]   rem_sh, diff;
    logic             fits;

    // restoring, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

### sv/ssrg_dp.sv
`timescale 1ns / 1ps
module ssrg_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssrg_pkg::t_dp_cmd    i_ctl,
    output ssrg_pkg::t_dp_stat   o_stat,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_addr,
    input  logic [15:0]          i_cfg_wdata,
    input  logic [1:0]           i_cmd,
    input  logic [23:0]          i_step_total,
    input  logic                 i_forward,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [15:0]          o_period,
    output logic [15:0]          o_compare_value,
    output logic                 o_pulse_enable,
    output logic                 o_clockwise,
    output logic                 o_busy_res,
    output logic [31:0]          o_steps_done,
    output logic [1:0]           o_phase
);
    import ssrg_pkg::*;

    // config
    logic [15:0] r_accel, r_decel, r_speed;
    // ramp state
    logic [1:0]  r_phase;
    logic        r_dir, r_moving, r_gen;
    logic [15:0] r_cur, r_floor, r_cruise;
    logic [31:0] r_idx, r_didx, r_dpt, r_rem, r_cnt;
    // latched request
    logic [1:0]  r_cmd;
    logic [23:0] r_steps;
    logic        r_fwd;
    // planning temporaries
    logic [18:0] r_x, r_m;
    logic [31:0] r_maxs, r_k;
    logic [23:0] r_lim;
    logic        r_kz;
    logic [15:0] r_nd;
    t_op         r_dst;
    logic        r_nneg, r_dneg;
    // isqrt
    logic [SQ_W-1:0] r_sx, r_root;
    logic [3:0]      r_sk;
    logic            r_sq_busy, r_sq_done;
    // output register
    logic        r_o_valid;
    logic [15:0] r_o_period, r_o_cmp;
    logic        r_o_en, r_o_cw, r_o_busy;
    logic [31:0] r_o_cnt;
    logic [1:0]  r_o_phase;

    logic [15:0] a_nz, d_nz, s_nz;
    logic        div_start, div_done;
    logic [NUM_W-1:0] div_num, dq;
    logic [DEN_W-1:0] div_den, drem;

    logic [31:0] idx_inc;
    logic signed [34:0] divv, den_mag;
    logic signed [33:0] numv, num_mag;
    logic [15:0] q16, nd_new;
    logic [31:0] rem_new;

    logic [SQ_W-1:0] sq_bit, sq_trial, sq_rnd;
    logic [33:0] first_full;
    logic [15:0] first16;
    logic [47:0] m_prod;
    logic        lim_le_max, dvz;
    logic [31:0] dv32, didx_new;
    logic        out_free;

    assign a_nz = (r_accel == '0) ? 16'd1 : r_accel;
    assign d_nz = (r_decel == '0) ? 16'd1 : r_decel;
    assign s_nz = (r_speed == '0) ? 16'd1 : r_speed;

    // accel scale a*628/100 by reciprocal multiply
    assign m_prod = 48'(a_nz) * 48'(M_RECIP);

    // delay step: (2*delay + rest) / (4*n + 1), truncating toward zero
    assign idx_inc = r_idx + 32'd1;
    assign divv    = {idx_inc[31], idx_inc, 2'b01};
    assign den_mag = divv[34] ? -divv : divv;
    assign numv    = $signed({17'd0, r_cur, 1'b0}) + $signed({{2{r_rem[31]}}, r_rem});
    assign num_mag = numv[33] ? -numv : numv;
    assign q16     = (r_nneg ^ r_dneg) ? (16'd0 - dq[15:0]) : dq[15:0];
    assign nd_new  = r_cur - q16;
    assign rem_new = r_nneg ? (32'd0 - drem[31:0]) : drem[31:0];

    always_comb begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        case (i_ctl.op)
            OP_DIV_FLOOR: begin
                div_num = NUM_W'(MIN_DELAY_NUM);
                div_den = DEN_W'(s_nz);
            end
            OP_DIV_X: begin
                div_num = NUM_W'(ALPHA_SQ_X);
                div_den = DEN_W'(a_nz);
            end
            OP_DIV_MAXS: begin
                div_num = NUM_W'(s_nz) * NUM_W'(s_nz);
                div_den = DEN_W'(r_m);
            end
            OP_DIV_LIM: begin
                div_num = NUM_W'(r_steps) * NUM_W'(d_nz);
                div_den = DEN_W'({1'b0, a_nz} + {1'b0, d_nz});
            end
            OP_DIV_K: begin
                div_num = NUM_W'(r_maxs) * NUM_W'(a_nz);
                div_den = DEN_W'(d_nz);
            end
            OP_DIV_DELAY: begin
                div_num = NUM_W'(unsigned'(num_mag));
                div_den = den_mag[DEN_W-1:0];
            end
            default: div_start = 1'b0;
        endcase
    end

    ssrg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (dq),
        .o_rem   (drem)
    );

    // isqrt digit step
    assign sq_bit   = SQ_W'(1) << {r_sk, 1'b0};
    assign sq_trial = r_root + sq_bit;
    assign sq_rnd   = (r_root < r_sx) ? r_root + 1'b1 : r_root;
    assign first_full = 34'(sq_rnd) * 34'(FIRST_SCALE);
    assign first16    = first_full[15:0];

    assign lim_le_max = {8'd0, r_lim} <= r_maxs;
    assign dv32       = lim_le_max ? ({8'd0, r_lim} - {8'd0, r_steps}) : (32'd0 - r_k);
    assign dvz        = lim_le_max ? (r_lim == r_steps) : r_kz;
    assign didx_new   = dvz ? 32'hFFFF_FFFF : dv32;

    assign out_free = !r_o_valid || !i_out_stall;

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel   <= ACCEL_RST;
            r_decel   <= DECEL_RST;
            r_speed   <= SPEED_RST;
            r_phase   <= PH_STOP;
            r_dir     <= 1'b0;
            r_moving  <= 1'b0;
            r_gen     <= 1'b0;
            r_cur     <= '0;
            r_floor   <= '0;
            r_cruise  <= '0;
            r_idx     <= '0;
            r_didx    <= '0;
            r_dpt     <= '0;
            r_rem     <= '0;
            r_cnt     <= '0;
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ACCEL: r_accel <= i_cfg_wdata;
                    CFG_DECEL: r_decel <= i_cfg_wdata;
                    CFG_SPEED: r_speed <= i_cfg_wdata;
                    default: ;
                endcase
            end

            r_sq_done <= r_sq_busy && (r_sk == '0);
            if (r_sq_busy && (r_sk == '0)) begin
                r_sq_busy <= 1'b0;
            end

            if (div_done) begin
                case (r_dst)
                    OP_DIV_FLOOR: r_floor <= dq[15:0];
                    OP_DIV_DELAY: r_rem   <= rem_new;
                    default: ;
                endcase
            end

            if (i_ctl.op == OP_EMIT) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            case (i_ctl.op)
                OP_SQRT: r_sq_busy <= 1'b1;
                OP_MOVE_SHORT: begin
                    r_dir <= r_fwd;
                    if (r_steps[0]) begin
                        r_idx    <= 32'hFFFF_FFFF;
                        r_phase  <= PH_DECEL;
                        r_cur    <= SINGLE_STEP_DELAY;
                        r_cnt    <= '0;
                        r_moving <= 1'b1;
                        r_gen    <= 1'b1;
                    end
                end
                OP_PLAN_END: begin
                    r_dir    <= r_fwd;
                    r_didx   <= didx_new;
                    r_dpt    <= {8'd0, r_steps} + didx_new;
                    if (first16 <= r_floor) begin
                        r_cur   <= r_floor;
                        r_phase <= PH_RUN;
                    end else begin
                        r_cur   <= first16;
                        r_phase <= PH_ACCEL;
                    end
                    r_idx    <= '0;
                    r_rem    <= '0;
                    r_cnt    <= '0;
                    r_cruise <= '0;
                    r_moving <= 1'b1;
                    r_gen    <= 1'b1;
                end
                OP_PULSE: r_cnt <= r_cnt + 32'd1;
                OP_HALT:  r_phase <= PH_STOP;
                OP_TICK_SIMPLE: begin
                    if (r_phase == PH_STOP) begin
                        r_cnt    <= '0;
                        r_rem    <= '0;
                        r_gen    <= 1'b0;
                        r_moving <= 1'b0;
                    end else if (r_cnt >= r_dpt) begin
                        r_idx   <= r_didx;
                        r_cur   <= r_cruise;
                        r_phase <= PH_DECEL;
                    end
                end
                OP_DIV_DELAY: r_idx <= idx_inc;
                OP_TICK_END: begin
                    if (r_phase == PH_ACCEL) begin
                        if (r_cnt >= r_dpt) begin
                            r_cur   <= r_nd;
                            r_idx   <= r_didx;
                            r_phase <= PH_DECEL;
                        end else if (r_nd <= r_floor) begin
                            r_cruise <= r_nd;
                            r_cur    <= r_floor;
                            r_rem    <= '0;
                            r_phase  <= PH_RUN;
                        end else begin
                            r_cur <= r_nd;
                        end
                    end else begin
                        r_cur <= r_nd;
                        if (!r_idx[31]) begin
                            r_phase <= PH_STOP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and temporaries
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_ACCEPT) begin
            r_cmd   <= i_cmd;
            r_steps <= i_step_total;
            r_fwd   <= i_forward;
        end
        if (div_start) begin
            r_dst  <= i_ctl.op;
            r_nneg <= numv[33];
            r_dneg <= divv[34];
        end
        if (i_ctl.op == OP_SCALE_M) begin
            r_m <= m_prod[M_SHIFT +: 19];
        end
        if (div_done) begin
            case (r_dst)
                OP_DIV_X:     r_x <= dq[18:0];
                OP_DIV_MAXS:  r_maxs <= (dq == '0) ? 32'd1 : dq[31:0];
                OP_DIV_LIM:   r_lim <= (dq == '0) ? 24'd1 : dq[23:0];
                OP_DIV_K: begin
                    r_k  <= dq[31:0];
                    r_kz <= (dq == '0);
                end
                OP_DIV_DELAY: r_nd <= nd_new;
                default: ;
            endcase
        end
        if (i_ctl.op == OP_SQRT) begin
            r_sx   <= SQ_W'(r_x);
            r_root <= '0;
            r_sk   <= SQ_FIRST;
        end else if (r_sq_busy) begin
            if (sq_trial <= r_sx) begin
                r_sx   <= r_sx - sq_trial;
                r_root <= (r_root >> 1) + sq_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_sk <= r_sk - 4'd1;
        end
        if (i_ctl.op == OP_EMIT) begin
            r_o_period <= r_cur;
            r_o_cmp    <= r_cur - PULSE_WIDTH;
            r_o_en     <= r_gen;
            r_o_cw     <= r_dir;
            r_o_busy   <= r_moving;
            r_o_cnt    <= r_cnt;
            r_o_phase  <= r_phase;
        end
    end

    assign o_stat.unit_done  = div_done || r_sq_done;
    assign o_stat.moving     = r_moving;
    assign o_stat.steps_lt2  = (r_steps[23:1] == '0);
    assign o_stat.cmd        = r_cmd;
    assign o_stat.phase      = r_phase;
    assign o_stat.lim_le_max = lim_le_max;
    assign o_stat.out_free   = out_free;

    assign o_out_valid     = r_o_valid;
    assign o_period        = r_o_period;
    assign o_compare_value = r_o_cmp;
    assign o_pulse_enable  = r_o_en;
    assign o_clockwise     = r_o_cw;
    assign o_busy_res      = r_o_busy;
    assign o_steps_done    = r_o_cnt;
    assign o_phase         = r_o_phase;
endmodule

### sv/ssrg_ctrl.sv
`timescale 1ns / 1ps
module ssrg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ssrg_pkg::t_dp_stat i_stat,
    output ssrg_pkg::t_dp_cmd  o_ctl,
    output logic               o_in_stall
);
    import ssrg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_X    = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_M    = 4'd4;
    localparam logic [3:0] S_MAXS = 4'd5;
    localparam logic [3:0] S_LIM  = 4'd6;
    localparam logic [3:0] S_K    = 4'd7;
    localparam logic [3:0] S_PLAN = 4'd8;
    localparam logic [3:0] S_TEND = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;
    localparam logic [3:0] S_WAIT = 4'd11;

    logic [3:0] r_state, n_state, r_ret, n_ret;
    t_op        op;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_EMIT;
                case (i_stat.cmd)
                    CMD_MOVE: begin
                        if (!i_stat.moving) begin
                            if (i_stat.steps_lt2) begin
                                op = OP_MOVE_SHORT;
                            end else begin
                                op      = OP_DIV_FLOOR;
                                n_ret   = S_X;
                                n_state = S_WAIT;
                            end
                        end
                    end
                    CMD_PULSE: op = OP_PULSE;
                    CMD_TICK: begin
                        if (i_stat.phase inside {PH_ACCEL, PH_DECEL}) begin
                            op      = OP_DIV_DELAY;
                            n_ret   = S_TEND;
                            n_state = S_WAIT;
                        end else begin
                            op = OP_TICK_SIMPLE;
                        end
                    end
                    default: op = OP_HALT;
                endcase
            end
            S_X: begin
                op = OP_DIV_X;  n_ret = S_SQ;   n_state = S_WAIT;
            end
            S_SQ: begin
                op = OP_SQRT;   n_ret = S_M;    n_state = S_WAIT;
            end
            S_M: begin
                op = OP_SCALE_M; n_state = S_MAXS;
            end
            S_MAXS: begin
                op = OP_DIV_MAXS; n_ret = S_LIM; n_state = S_WAIT;
            end
            S_LIM: begin
                op = OP_DIV_LIM; n_ret = S_K;   n_state = S_WAIT;
            end
            S_K: begin
                if (i_stat.lim_le_max) begin
                    n_state = S_PLAN;
                end else begin
                    op = OP_DIV_K; n_ret = S_PLAN; n_state = S_WAIT;
                end
            end
            S_PLAN: begin
                op      = OP_PLAN_END;
                n_state = S_EMIT;
            end
            S_TEND: begin
                op      = OP_TICK_END;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    op      = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                if (i_stat.unit_done) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_ctl.op   = op;
    assign o_in_stall = (r_state != S_IDLE);
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import ssrg_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        logic [23:0] steps;
        logic        fwd;
    } req_t;

    typedef struct {
        logic [15:0] period;
        logic [15:0] compare;
        logic        pulse_en;
        logic        cw;
        logic        busy;
        logic [31:0] count;
        logic [1:0]  phase;
    } ramp_res_t;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid, o_in_stall;
    logic [1:0]  i_cmd;
    logic [23:0] i_step_total;
    logic        i_forward;
    logic        o_out_valid, i_out_stall;
    logic [15:0] o_period, o_compare_value;
    logic        o_pulse_enable, o_clockwise, o_busy_res;
    logic [31:0] o_steps_done;
    logic [1:0]  o_phase;

    stepper_speed_ramp_generator dut (.*);

    // ramp model state
    logic [15:0] cfg_accel, cfg_decel, cfg_speed;
    logic [1:0]  m_phase;
    logic        m_cw, m_moving, m_gen_on;
    logic [15:0] m_delay, m_floor, m_cruise;
    logic [31:0] m_index, m_dec_index, m_dec_point, m_rest, m_count;

    req_t      req_q[$];
    ramp_res_t ramp_q[$];
    int        n_errors;
    int        stuck_cycles;
    bit        quiet;
    bit        in_taken;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] root_round(logic [31:0] x);
        logic [31:0] root, b;
        root = 0;
        b = 32'h4000_0000;
        while (b != 0) begin
            if (root + b <= x) begin
                x = x - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return (root < x) ? root + 1 : root;
    endfunction

    // remainder-carrying delay update: delay -= (2*delay+rest)/(4n+1)
    function automatic logic [15:0] delay_update();
        longint n, dv, num, q;
        n = longint'(signed'(m_index));
        dv = 4 * n + 1;
        num = 2 * longint'(m_delay) + longint'(signed'(m_rest));
        q = num / dv;
        m_rest = 32'(num % dv);
        return 16'(longint'(m_delay) - q);
    endfunction

    function automatic void plan_ramp(logic [23:0] steps);
        longint unsigned a, d, s, first, max_s, lim, st;
        longint dv;
        a = (cfg_accel == 0) ? 1 : cfg_accel;
        d = (cfg_decel == 0) ? 1 : cfg_decel;
        s = (cfg_speed == 0) ? 1 : cfg_speed;
        st = steps;
        m_floor = 16'(64'd6000000 / s);
        first = (64'd1000000 * root_round(32'(64'd394384 / a))) / 100;
        max_s = (s * s) / ((64'd628 * a) / 100);
        if (max_s == 0) max_s = 1;
        lim = (st * d) / (a + d);
        if (lim == 0) lim = 1;
        if (lim <= max_s) dv = longint'(lim) - longint'(st);
        else dv = -longint'((max_s * a) / d);
        if (dv == 0) dv = -1;
        m_dec_index = 32'(dv);
        m_dec_point = 32'(longint'(st) + dv);
        m_delay = first[15:0];
        if (m_delay <= m_floor) begin
            // already at or above cruise speed
            m_delay = m_floor;
            m_phase = PH_RUN;
        end else begin
            m_phase = PH_ACCEL;
        end
        m_index = 0;
        m_rest = 0;
        m_count = 0;
        m_cruise = 0;
        m_moving = 1;
        m_gen_on = 1;
    endfunction

    function automatic void ramp_tick();
        logic [15:0] nd;
        case (m_phase)
            PH_STOP: begin
                m_count = 0;
                m_rest = 0;
                m_gen_on = 0;
                m_moving = 0;
            end
            PH_ACCEL: begin
                m_index = m_index + 1;
                nd = delay_update();
                if (m_count >= m_dec_point) begin
                    m_index = m_dec_index;
                    m_phase = PH_DECEL;
                end else if (nd <= m_floor) begin
                    m_cruise = nd;
                    nd = m_floor;
                    m_rest = 0;
                    m_phase = PH_RUN;
                end
                m_delay = nd;
            end
            PH_RUN: begin
                if (m_count >= m_dec_point) begin
                    m_index = m_dec_index;
                    m_delay = m_cruise;
                    m_phase = PH_DECEL;
                end
            end
            default: begin
                m_index = m_index + 1;
                nd = delay_update();
                if (signed'(m_index) >= 0) m_phase = PH_STOP;
                m_delay = nd;
            end
        endcase
    endfunction

    function automatic ramp_res_t predict_ramp(req_t r);
        ramp_res_t e;
        case (r.cmd)
            CMD_MOVE: begin
                if (!m_moving) begin
                    m_cw = r.fwd;
                    if (r.steps == 1) begin
                        // single step: straight into deceleration
                        m_index = 32'hFFFF_FFFF;
                        m_phase = PH_DECEL;
                        m_delay = SINGLE_STEP_DELAY;
                        m_count = 0;
                        m_moving = 1;
                        m_gen_on = 1;
                    end else if (r.steps != 0) begin
                        plan_ramp(r.steps);
                    end
                end
            end
            CMD_PULSE: m_count = m_count + 1;
            CMD_TICK:  ramp_tick();
            default:   m_phase = PH_STOP;
        endcase
        e.period = m_delay;
        e.compare = m_delay - PULSE_WIDTH;
        e.pulse_en = m_gen_on;
        e.cw = m_cw;
        e.busy = m_moving;
        e.count = m_count;
        e.phase = m_phase;
        return e;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // request driver: a new request only once the last one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_taken = 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (req_q.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
                i_cmd <= req_q[0].cmd;
                i_step_total <= req_q[0].steps;
                i_forward <= req_q[0].fwd;
                void'(req_q.pop_front());
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= !quiet && $urandom_range(99) < 7;
    end

    // accept, predict, check
    always @(posedge i_clk) begin
        req_t      r;
        ramp_res_t e;
        bit        moved;
        moved = 0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            r.cmd = i_cmd;
            r.steps = i_step_total;
            r.fwd = i_forward;
            ramp_q.push_back(predict_ramp(r));
            in_taken = 1'b1;
            moved = 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved = 1;
            if (ramp_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                e = ramp_q.pop_front();
                if (o_period !== e.period) report("period", o_period, e.period);
                if (o_compare_value !== e.compare)
                    report("compare_value", o_compare_value, e.compare);
                if (o_pulse_enable !== e.pulse_en)
                    report("pulse_enable", o_pulse_enable, e.pulse_en);
                if (o_clockwise !== e.cw) report("clockwise", o_clockwise, e.cw);
                if (o_busy_res !== e.busy) report("busy_res", o_busy_res, e.busy);
                if (o_steps_done !== e.count) report("steps_done", o_steps_done, e.count);
                if (o_phase !== e.phase) report("phase", o_phase, e.phase);
            end
        end
        // watchdog: only while work is outstanding
        if (moved || (req_q.size() == 0 && !i_in_valid && ramp_q.size() == 0))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= 20000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] addr, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        case (addr)
            CFG_ACCEL: cfg_accel = val;
            CFG_DECEL: cfg_decel = val;
            default:   cfg_speed = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_profile(logic [15:0] a, logic [15:0] d, logic [15:0] s);
        write_reg(CFG_ACCEL, a);
        write_reg(CFG_DECEL, d);
        write_reg(CFG_SPEED, s);
    endtask

    task automatic add_req(logic [1:0] c, logic [23:0] n, logic f);
        req_t r;
        r.cmd = c;
        r.steps = n;
        r.fwd = f;
        req_q.push_back(r);
    endtask

    // wait for every result, then let the divider go quiet
    task automatic drain();
        while (req_q.size() != 0 || i_in_valid || ramp_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // usually one move, then ticks, pulses, stops and moves, usually closed by a stop
    task automatic add_move_seq();
        int          len, pick;
        logic [23:0] n;
        pick = $urandom_range(99);
        if (pick < 70) n = 24'($urandom_range(40, 1));
        else if (pick < 85) n = 24'($urandom_range(3, 0));
        else n = 24'($urandom);
        if ($urandom_range(9) == 0)
            add_req(2'($urandom_range(3)), 24'($urandom), 1'($urandom_range(1)));
        else add_req(CMD_MOVE, n, 1'($urandom_range(1)));
        len = $urandom_range(25, 5);
        repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 60) add_req(CMD_TICK, 24'($urandom), 1'($urandom_range(1)));
            else if (pick < 90) add_req(CMD_PULSE, 24'($urandom), 1'($urandom_range(1)));
            else if (pick < 95) add_req(CMD_STOP, 24'($urandom), 1'($urandom_range(1)));
            else add_req(CMD_MOVE, 24'($urandom), 1'($urandom_range(1)));
        end
        if ($urandom_range(9) < 8) begin
            add_req(CMD_STOP, 0, 0);
            add_req(CMD_TICK, 0, 0);
        end
    endtask

    initial begin
        int done;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_ACCEL;
        i_cfg_wdata = 16'd0;
        i_in_valid = 1'b0;
        i_cmd = CMD_TICK;
        i_step_total = 24'd0;
        i_forward = 1'b0;
        i_out_stall = 1'b0;
        n_errors = 0;
        stuck_cycles = 0;
        quiet = 0;
        in_taken = 0;
        cfg_accel = ACCEL_RST;
        cfg_decel = DECEL_RST;
        cfg_speed = SPEED_RST;
        m_phase = PH_STOP;
        {m_cw, m_moving, m_gen_on} = '0;
        {m_delay, m_floor, m_cruise} = '0;
        {m_index, m_dec_index, m_dec_point, m_rest, m_count} = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero-step move, single step, short moves, stop, largest move, pulses
        add_req(CMD_MOVE, 24'd0, 1'b1);
        add_req(CMD_TICK, 24'd0, 1'b0);
        add_req(CMD_MOVE, 24'd1, 1'b0);
        add_req(CMD_MOVE, 24'd5, 1'b1);
        add_req(CMD_PULSE, 24'd0, 1'b0);
        add_req(CMD_TICK, 24'd0, 1'b0);
        add_req(CMD_STOP, 24'd0, 1'b0);
        add_req(CMD_TICK, 24'd0, 1'b0);
        add_req(CMD_MOVE, 24'hFF_FFFF, 1'b0);
        repeat (3) add_req(CMD_TICK, 24'h00_0000, 1'b1);
        add_req(CMD_PULSE, 24'hFF_FFFF, 1'b1);
        add_req(CMD_STOP, 24'd0, 1'b0);
        add_req(CMD_TICK, 24'd0, 1'b0);
        add_req(CMD_MOVE, 24'd2, 1'b1);
        add_req(CMD_PULSE, 24'd0, 1'b0);
        repeat (4) add_req(CMD_TICK, 24'd0, 1'b0);
        add_req(CMD_STOP, 24'd0, 1'b0);
        add_req(CMD_TICK, 24'd0, 1'b0);
        drain();

        // random phases over several profiles, extremes first
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_profile(16'd1, 16'd1, 16'd1);
                1: set_profile(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_profile(16'd0, 16'd0, 16'd0);
                3: set_profile(16'hFFFF, 16'd1, 16'hFFFF);
                4: set_profile(16'd1, 16'hFFFF, 16'd1);
                5: set_profile(ACCEL_RST, DECEL_RST, SPEED_RST);
                default: set_profile(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            quiet = (ph == 3);
            done = 0;
            while (done < 150) begin
                add_move_seq();
                done = done + 20;
            end
            drain();
        end
        quiet = 0;

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
